[design/cop_pkg.sv]
// Package for the circular orbit position block.
// Holds the shared sizes, the register indexes, the CORDIC angle table, the controller
// state type and the command struct. It depends on nothing else.
`default_nettype none

package cop_pkg;

  // Sizes of the phase, of a position and of the rotation loop.
  localparam int PHASE_BITS   = 16;
  localparam int POS_BITS     = 32;
  localparam int CORDIC_STEPS = 16;

  // Width of the register write data; the radius is the widest register.
  localparam int CFG_DATA_W = 31;
  localparam int CFG_ADDR_W = 2;

  // Width of the rotation step counter.
  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RADIUS       = 2'd0,
    REG_ANGULAR_STEP = 2'd1,
    REG_START_ANGLE  = 2'd2
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_TRIG,
    ST_PROD,
    ST_SUM
  } cop_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              start;
    logic              rotate;
    logic [ITER_W-1:0] iter;
    logic              trig;
    logic              prod;
    logic              load_out;
  } cop_cmd_t;

  // Angle of atan(2^-i) in units of 2^32 per turn.
  function automatic logic signed [31:0] atan_turn32(input logic [4:0] i);
    logic signed [31:0] a;
    unique case (i)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10679838;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2608;
      5'd19:   a = 32'sd1304;
      5'd20:   a = 32'sd652;
      5'd21:   a = 32'sd326;
      5'd22:   a = 32'sd163;
      5'd23:   a = 32'sd81;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[design/cop_ctrl.sv]
// Controller for the circular orbit position block.
// Sequences accept, rotation steps, trig rounding, product and sum, and owns
// the output valid flag. Depends on cop_pkg.
`default_nettype none

module cop_ctrl
  import cop_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cop_cmd_t      cmd
);

  cop_state_t        state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              last_step;

  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (cnt_r == ITER_W'(CORDIC_STEPS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_ROT;
      ST_ROT:  if (last_step) state_nxt = ST_TRIG;
      ST_TRIG: state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_SUM;
      ST_SUM:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd           = '0;
    cmd.iter      = cnt_r;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_ROT:  cmd.rotate = 1'b1;
      ST_TRIG: cmd.trig = 1'b1;
      ST_PROD: cmd.prod = 1'b1;
      ST_SUM:  cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // Step counter runs only through the rotation steps.
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_ROT) begin
      cnt_nxt = last_step ? '0 : cnt_r + 1'b1;
    end
  end

  // Output valid is set by a load and cleared by a completed transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[design/cop_datapath.sv]
// Datapath for the circular orbit position block.
// Holds the registers, the phase, one shared CORDIC stage, the radius multipliers
// and the saturating adders. Depends on cop_pkg.
`default_nettype none

module cop_datapath
  import cop_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  input  wire logic signed [POS_BITS-1:0]   in_anchor_x,
  input  wire logic signed [POS_BITS-1:0]   in_anchor_y,
  input  wire cop_cmd_t                     cmd,
  output logic signed [POS_BITS-1:0]        out_pos_x,
  output logic signed [POS_BITS-1:0]        out_pos_y,
  output logic                              out_clipped
);

  // Rotation values are Q2.30 with headroom; z is in 2^32 per turn.
  localparam int CW      = 34;
  localparam int ZW      = 32;
  localparam int PROD_W  = 48;
  localparam int OFF_W   = PROD_W - 15;
  localparam int SUM_W   = ((POS_BITS > OFF_W) ? POS_BITS : OFF_W) + 1;
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032875);

  logic [30:0]               radius_r;
  logic signed [15:0]        step_r;
  logic [PHASE_BITS-1:0]     phase_r;
  logic [PHASE_BITS-1:0]     phase_next;
  logic [31:0]               phase_sum;
  logic [31:0]               angle32;
  logic [1:0]                quad_r;
  logic signed [CW-1:0]      x_r, y_r;
  logic signed [ZW-1:0]      z_r;
  logic signed [CW-1:0]      dx, dy;
  logic signed [ZW-1:0]      da;
  logic signed [POS_BITS-1:0] ax_r, ay_r;
  logic signed [15:0]        cos_q15, sin_q15;
  logic signed [15:0]        cs_r, sn_r;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r;
  logic signed [PROD_W-1:0]  radius_ext;
  logic signed [PROD_W-1:0]  shift_x, shift_y;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic                      ovf_x, ovf_y;
  logic signed [POS_BITS-1:0] sat_x, sat_y;

  // Round a Q2.30 value to Q1.15 and keep it in the symmetric range.
  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [15:0]   q;
    r = (v + CW'(16384)) >>> 15;
    if (r > CW'(32767)) begin
      q = 16'sd32767;
    end else if (r < -CW'(32767)) begin
      q = -16'sd32767;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  // Saturation of a wide sum to the position range.
  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-POS_BITS:0]     top;
    logic signed [POS_BITS-1:0]  r;
    top = s[SUM_W-1:POS_BITS-1];
    if (&top || !(|top)) begin
      r = s[POS_BITS-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(POS_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // Configuration registers; a start angle write also loads the phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      step_r   <= '0;
      phase_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RADIUS:       radius_r <= cfg_data;
        REG_ANGULAR_STEP: step_r   <= cfg_data[15:0];
        REG_START_ANGLE:  phase_r  <= PHASE_BITS'(32'(cfg_data[15:0]));
        default:          ;
      endcase
    end else if (cmd.start) begin
      phase_r <= phase_next;
    end
  end

  // Phase advance wraps modulo a full turn for either sign of step.
  assign phase_sum  = 32'(phase_r) + 32'(step_r);
  assign phase_next = phase_sum[PHASE_BITS-1:0];
  assign angle32    = 32'(phase_next) << (32 - PHASE_BITS);

  // One CORDIC rotation per cycle, shifts and angle chosen by the step index.
  assign dx = y_r >>> cmd.iter;
  assign dy = x_r >>> cmd.iter;
  assign da = atan_turn32(5'(cmd.iter));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ax_r   <= in_anchor_x;
      ay_r   <= in_anchor_y;
      quad_r <= angle32[31:30];
      z_r    <= {2'b00, angle32[29:0]};
      x_r    <= GAIN_Q30;
      y_r    <= '0;
    end else if (cmd.rotate) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end
    end
  end

  // Round to Q1.15 and fold in the quadrant.
  assign cos_q15 = to_q15(x_r);
  assign sin_q15 = to_q15(y_r);

  always_ff @(posedge clk) begin
    if (cmd.trig) begin
      unique case (quad_r)
        2'd0: begin cs_r <= cos_q15;  sn_r <= sin_q15;  end
        2'd1: begin cs_r <= -sin_q15; sn_r <= cos_q15;  end
        2'd2: begin cs_r <= -cos_q15; sn_r <= -sin_q15; end
        default: begin cs_r <= sin_q15; sn_r <= -cos_q15; end
      endcase
    end
  end

  // Radius times cosine and sine, Q16.16 by Q1.15.
  assign radius_ext = PROD_W'($signed({1'b0, radius_r}));

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      prod_x_r <= radius_ext * PROD_W'(cs_r);
      prod_y_r <= radius_ext * PROD_W'(sn_r);
    end
  end

  // Back to Q16.16, add the anchor and saturate.
  assign shift_x = (prod_x_r + PROD_W'(16384)) >>> 15;
  assign shift_y = (prod_y_r + PROD_W'(16384)) >>> 15;
  assign sum_x   = SUM_W'(ax_r) + SUM_W'($signed(shift_x[OFF_W-1:0]));
  assign sum_y   = SUM_W'(ay_r) + SUM_W'($signed(shift_y[OFF_W-1:0]));
  assign sat_x   = sat_pos(sum_x);
  assign sat_y   = sat_pos(sum_y);
  assign ovf_x   = (sat_x != sum_x[POS_BITS-1:0]);
  assign ovf_y   = (sat_y != sum_y[POS_BITS-1:0]);

  // Output register parts the datapath from the result channel.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pos_x   <= sat_x;
      out_pos_y   <= sat_y;
      out_clipped <= ovf_x || ovf_y;
    end
  end

endmodule

`default_nettype wire

[design/circular_orbit_position.sv]
// Top level of the circular orbit position block.
// Joins the controller and the datapath. Depends on cop_pkg, cop_ctrl and cop_datapath.
//
// Each accepted input transfer is one tick carrying an anchor point. The tick adds
// angular_step to the kept phase (a full turn is 2^16 units, wrapping either way),
// runs a 16-step CORDIC on the new phase, and returns anchor plus radius times
// (cos, sin) in signed Q16.16, saturated, with clipped set if either coordinate
// saturated. Each item passes from acceptance to a loaded result in this order: accept,
// one rotation per step through the single shared CORDIC stage, then trig rounding,
// the radius multiply and the final sum, which waits until the output register is free.
// The block holds one item at a time; the result sits in an output register, so
// the next item is accepted as soon as the previous one is loaded there. Write
// the registers only while the block is idle, since a write takes effect at once;
// writing start_angle also loads the phase.
`default_nettype none

module circular_orbit_position
  import cop_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [POS_BITS-1:0]  in_anchor_x,
  input  wire logic signed [POS_BITS-1:0]  in_anchor_y,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [POS_BITS-1:0]       out_pos_x,
  output logic signed [POS_BITS-1:0]       out_pos_y,
  output logic                             out_clipped
);

  cop_cmd_t cmd;

  // Sequencing of each tick.
  cop_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Registers, phase, CORDIC and output arithmetic.
  cop_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_anchor_x (in_anchor_x),
    .in_anchor_y (in_anchor_y),
    .cmd         (cmd),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_clipped (out_clipped)
  );

endmodule

`default_nettype wire

[sim/orbit_position_checker.sv]
// Checker for the circular orbit position block: watches the register port and both channels.
// Predicts each result from its own copy of the registers and the phase, compares it with
// the result transfer, and reports counts to the testbench top. Depends on cop_pkg.
`timescale 1ns / 1ps

module orbit_position_checker
  import cop_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [POS_BITS-1:0] in_anchor_x,
  input  logic signed [POS_BITS-1:0] in_anchor_y,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [POS_BITS-1:0] out_pos_x,
  input  logic signed [POS_BITS-1:0] out_pos_y,
  input  logic                       out_clipped,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic                       clipped;
  } point_t;

  // Gain-compensated start vector of the rotation, Q2.30.
  localparam longint ROT_GAIN_Q30 = 64'sd652032875;
  localparam longint POS_HI       = 64'sd2147483647;
  localparam longint POS_LO       = -64'sd2147483648;

  // Shadow copy of the block's registers and phase.
  logic [30:0]        radius_r;
  logic signed [15:0] step_r;
  logic [15:0]        phase_r;

  point_t predicted_points[$];
  int     n_bad = 0;

  // Rotation angle atan(2^-i), 2^32 units per turn.
  function automatic longint rotation_angle(input int i);
    longint a;
    case (i)
      0:       a = 536870912;
      1:       a = 316933406;
      2:       a = 167458907;
      3:       a = 85004756;
      4:       a = 42667331;
      5:       a = 21354465;
      6:       a = 10679838;
      7:       a = 5340245;
      8:       a = 2670163;
      9:       a = 1335087;
      10:      a = 667544;
      11:      a = 333772;
      12:      a = 166886;
      13:      a = 83443;
      14:      a = 41722;
      default: a = 20861;
    endcase
    return a;
  endfunction

  // Q2.30 to Q1.15 with rounding, kept symmetric around zero.
  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  // Clamp a coordinate to the signed position range and note any clipping.
  function automatic longint clamp_pos(input longint v, inout logic clip);
    if (v > POS_HI) begin
      clip = 1'b1;
      return POS_HI;
    end
    if (v < POS_LO) begin
      clip = 1'b1;
      return POS_LO;
    end
    return v;
  endfunction

  // Position on the orbit at phase ph around the anchor point.
  function automatic point_t orbit_point(input logic [15:0] ph, input logic [30:0] rad,
                                         input logic signed [31:0] ax,
                                         input logic signed [31:0] ay);
    logic [1:0] quad;
    longint     xr, yr, zr, dx, dy, c, s, cs, sn, rad_l, ax_l, ay_l, ox, oy;
    logic       clip;
    point_t     p;
    quad  = ph[15:14];
    zr    = {34'd0, ph[13:0], 16'd0};
    xr    = ROT_GAIN_Q30;
    yr    = 0;
    rad_l = rad;
    ax_l  = ax;
    ay_l  = ay;
    clip  = 1'b0;
    // Rotate toward the angle within the first quadrant.
    for (int i = 0; i < 16; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (zr >= 0) begin
        xr = xr - dx;
        yr = yr + dy;
        zr = zr - rotation_angle(i);
      end else begin
        xr = xr + dx;
        yr = yr - dy;
        zr = zr + rotation_angle(i);
      end
    end
    c = round_q15(xr);
    s = round_q15(yr);
    // Fold the quadrant back in.
    case (quad)
      2'd0: begin cs = c;  sn = s;  end
      2'd1: begin cs = -s; sn = c;  end
      2'd2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
    ox = (rad_l * cs + 16384) >>> 15;
    oy = (rad_l * sn + 16384) >>> 15;
    p.pos_x   = 32'(clamp_pos(ax_l + ox, clip));
    p.pos_y   = 32'(clamp_pos(ay_l + oy, clip));
    p.clipped = clip;
    return p;
  endfunction

  // Compare result transfers, track register writes, predict each input transfer.
  always @(posedge clk) begin : watch
    point_t got;
    point_t want;
    if (!rst_n) begin
      radius_r = '0;
      step_r   = '0;
      phase_r  = '0;
      predicted_points.delete();
      n_bad    = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.pos_x   = out_pos_x;
        got.pos_y   = out_pos_y;
        got.clipped = out_clipped;
        if (predicted_points.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: unexpected result x=%0d y=%0d clipped=%0b",
                     $realtime, got.pos_x, got.pos_y, got.clipped);
        end else begin
          want = predicted_points.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: mismatch x=%0d/%0d y=%0d/%0d clipped=%0b/%0b (expected/actual)",
                       $realtime, want.pos_x, got.pos_x, want.pos_y, got.pos_y,
                       want.clipped, got.clipped);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_RADIUS:       radius_r = cfg_data[30:0];
          REG_ANGULAR_STEP: step_r   = cfg_data[15:0];
          REG_START_ANGLE:  phase_r  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        phase_r = phase_r + step_r;
        predicted_points.push_back(orbit_point(phase_r, radius_r, in_anchor_x, in_anchor_y));
      end
    end
    mismatches  <= n_bad;
    outstanding <= predicted_points.size();
  end

endmodule

[sim/circular_orbit_position_tb.sv]
// Testbench top for the circular orbit position block: clock, reset, register writes and
// tick stimulus with random idling on both channels. Depends on cop_pkg, the block and
// orbit_position_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module circular_orbit_position_tb;
  import cop_pkg::*;

  localparam logic [CFG_ADDR_W-1:0]  REG_UNUSED = 2'd3;
  localparam logic signed [31:0]     POS_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]     POS_MIN    = 32'sh8000_0000;
  localparam logic [30:0]            RADIUS_MAX = 31'h7FFF_FFFF;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_ADDR_W-1:0]      cfg_addr;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [POS_BITS-1:0] in_anchor_x;
  logic signed [POS_BITS-1:0] in_anchor_y;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic signed [POS_BITS-1:0] out_pos_x;
  logic signed [POS_BITS-1:0] out_pos_y;
  logic                       out_clipped;
  int                         mismatches;
  int                         outstanding;

  bit idle_on = 1'b1;
  int ready_hold = 0;

  circular_orbit_position dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_anchor_x (in_anchor_x),
    .in_anchor_y (in_anchor_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_clipped (out_clipped)
  );

  orbit_position_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_anchor_x (in_anchor_x),
    .in_anchor_y (in_anchor_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_clipped (out_clipped),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // Receiver stalls in random bursts while idling is enabled.
  always @(posedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      ready_hold <= $urandom_range(1, 11);
    end
  end

  // Start a register write; a following write or cfg_end closes it.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [30:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
  endtask

  task automatic cfg_end();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One tick transfer, with an optional gap ahead of it.
  task automatic send_tick(input logic signed [31:0] ax, input logic signed [31:0] ay);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_anchor_x <= ax;
    in_anchor_y <= ay;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = POS_MAX;
      1:       v = POS_MIN;
      2:       v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] pick_radius();
    logic [30:0] r;
    case ($urandom_range(0, 7))
      0:       r = '0;
      1:       r = RADIUS_MAX;
      2, 3:    r = 31'($urandom_range(0, 32'h00FF_FFFF));
      default: r = 31'($urandom);
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pick_step();
    logic [15:0] s;
    case ($urandom_range(0, 9))
      0:       s = 16'h0000;
      1:       s = 16'h7FFF;
      2:       s = 16'h8000;
      3:       s = 16'h0001;
      4:       s = 16'hFFFF;
      5:       s = 16'h4000;
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  // New random settings; the upper data bits of the short registers carry noise.
  task automatic random_settings();
    logic [30:0] d;
    write_reg(REG_RADIUS, pick_radius());
    d = 31'($urandom);
    d[15:0] = pick_step();
    write_reg(REG_ANGULAR_STEP, d);
    if ($urandom_range(0, 1) == 0) begin
      d = 31'($urandom);
      if ($urandom_range(0, 3) == 0) d[15:0] = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'hFFFF;
      write_reg(REG_START_ANGLE, d);
    end
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_UNUSED, 31'($urandom));
    cfg_end();
  endtask

  initial begin
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_anchor_x = '0;
    in_anchor_y = '0;
    rst_n       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero radius passes the anchor through.
    send_tick(32'sd0, 32'sd0);
    send_tick(POS_MAX, POS_MIN);
    drain();

    // Unit radius at phase zero: cosine of exactly one is clamped.
    write_reg(REG_RADIUS, 31'd65536);
    write_reg(REG_ANGULAR_STEP, 31'h7FFF_0000);
    write_reg(REG_START_ANGLE, 31'h0);
    cfg_end();
    send_tick(32'sd0, 32'sd0);
    drain();

    // Quarter-turn steps visit every quadrant and wrap back to zero.
    write_reg(REG_ANGULAR_STEP, 31'd16384);
    cfg_end();
    repeat (4) send_tick(32'sd0, 32'sd0);
    send_tick(-32'sd65536, 32'sd65536);
    drain();

    // Most negative step from the top of the phase range; unknown index is ignored.
    write_reg(REG_ANGULAR_STEP, 31'h5555_8000);
    write_reg(REG_START_ANGLE, 31'h2AAA_FFFF);
    write_reg(REG_UNUSED, 31'h7FFF_FFFF);
    cfg_end();
    repeat (2) send_tick(32'sd0, 32'sd0);
    drain();

    // Largest radius and step with extreme anchors: saturation both ways.
    write_reg(REG_RADIUS, RADIUS_MAX);
    write_reg(REG_ANGULAR_STEP, 31'h0000_7FFF);
    cfg_end();
    send_tick(32'sd0, 32'sd0);
    send_tick(POS_MAX, POS_MAX);
    send_tick(POS_MIN, POS_MIN);
    send_tick(POS_MAX, POS_MIN);
    send_tick(POS_MIN, POS_MAX);
    send_tick(32'sd0, 32'sd0);
    drain();

    write_reg(REG_RADIUS, 31'd1);
    write_reg(REG_ANGULAR_STEP, 31'h1234_0001);
    write_reg(REG_START_ANGLE, 31'h6543_4000);
    cfg_end();
    repeat (2) send_tick(pick_coord(), pick_coord());
    drain();

    // Random phases; the last one runs without idling on either side.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) idle_on = 1'b0;
      random_settings();
      for (int n = 0; n < 150; n++) begin
        if (ph == 2 && n == 75) drain();
        send_tick(pick_coord(), pick_coord());
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("circular_orbit_position_tb: clean");
    end else begin
      $display("circular_orbit_position_tb: errors");
    end
    $finish;
  end

  // Run limit far beyond the slowest correct run.
  initial begin
    #(24_000_000);
    $display("circular_orbit_position_tb: errors");
    $finish;
  end

endmodule

[circular_orbit_position.f]
design/cop_pkg.sv
design/cop_ctrl.sv
design/cop_datapath.sv
design/circular_orbit_position.sv
sim/orbit_position_checker.sv
sim/circular_orbit_position_tb.sv
